### src/bra_pkg.sv
// package for the bitmap run allocator: sizes, operation codes and sequencer states
package bra_pkg;

  localparam int MaxBytes = 512;
  localparam int AddrW    = $clog2(MaxBytes);
  localparam int ByteW    = 8;
  localparam int BitOffW  = $clog2(ByteW);

  localparam int CfgW     = 10;
  localparam int FuncW    = 3;
  localparam int IndexW   = 12;
  localparam int LenW     = 13;

  localparam logic [FuncW-1:0] OpTest  = 3'd0;
  localparam logic [FuncW-1:0] OpSet   = 3'd1;
  localparam logic [FuncW-1:0] OpClear = 3'd2;
  localparam logic [FuncW-1:0] OpScan  = 3'd3;
  localparam logic [FuncW-1:0] OpWipe  = 3'd4;

  localparam logic [CfgW-1:0] BytesInUseReset = 10'd512;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_BITOP,
    ST_SCAN,
    ST_WIPE,
    ST_OUT
  } state_t;

endpackage

### src/bitmap_run_allocator.sv
// bitmap run allocator: byte-wide mark store with a byte-per-cycle run scanner
// test, set and clear read the addressed byte and then write it back or report the bit;
// out-of-range and rejected requests go straight to the result; a scan walks the stored
// bytes in order (up to 512); clear all sweeps the whole store. one request at a time
// reset clears control state and then sweeps the store to zero, during which no
// request is taken; configuration writes are taken at any time
module bitmap_run_allocator
  import bra_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // func[2:0], bit_index[14:3], run_length[27:15], zero[31:28]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,
  // bit_value[0], found[1], start_index[13:2], range_error[14], zero[15]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_t state, state_next;

  logic [ByteW-1:0] mem [MaxBytes];
  logic [ByteW-1:0] rdata;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [ByteW-1:0] mem_wdata;
  logic [AddrW-1:0] mem_raddr;

  logic [CfgW-1:0]   bytes_in_use;
  logic [CfgW-1:0]   nbytes;
  logic [CfgW-1:0]   nbytes_m1;
  logic [LenW-1:0]   limit;

  logic [FuncW-1:0]  in_func;
  logic [IndexW-1:0] in_pos;
  logic [LenW-1:0]   in_want;
  logic              in_xfer;
  logic              in_indexed;
  logic              in_bad_index;
  logic              in_scan_ok;

  logic [FuncW-1:0]  op;
  logic [IndexW-1:0] pos;
  logic [LenW-1:0]   want;
  logic [LenW-1:0]   run;
  logic [AddrW-1:0]  byte_cnt;
  logic [AddrW-1:0]  clr_addr;

  logic              scan_hit;
  logic [BitOffW-1:0] scan_off;
  logic [LenW-1:0]   scan_run;
  logic [LenW-1:0]   scan_end;
  logic [LenW-1:0]   scan_start;
  logic              scan_last;

  logic              res_bit;
  logic              res_found;
  logic [IndexW-1:0] res_start;
  logic              res_err;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_use <= BytesInUseReset;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      bytes_in_use <= pwdata[CfgW-1:0];
    end
  end

  assign prdata = (paddr[2] == 1'b0) ? {{(32-CfgW){1'b0}}, bytes_in_use} : 32'd0;

  assign nbytes    = (bytes_in_use > CfgW'(MaxBytes)) ? CfgW'(MaxBytes) : bytes_in_use;
  assign nbytes_m1 = nbytes - CfgW'(1);
  assign limit     = {nbytes, {BitOffW{1'b0}}};

  // request decode
  assign in_func      = s_tdata[FuncW-1:0];
  assign in_pos       = s_tdata[FuncW+IndexW-1:FuncW];
  assign in_want      = s_tdata[FuncW+IndexW+LenW-1:FuncW+IndexW];
  assign in_xfer      = s_tvalid && s_tready;
  assign in_indexed   = (in_func == OpTest) || (in_func == OpSet) || (in_func == OpClear);
  assign in_bad_index = {1'b0, in_pos} >= limit;
  assign in_scan_ok   = (in_want != '0) && (in_want <= limit);

  // run count across one stored byte
  always_comb begin
    scan_run = run;
    scan_hit = 1'b0;
    scan_off = '0;
    for (int j = 0; j < ByteW; j++) begin
      if (!scan_hit) begin
        if (rdata[j]) begin
          scan_run = '0;
        end else begin
          scan_run = scan_run + LenW'(1);
        end
        if (scan_run == want) begin
          scan_hit = 1'b1;
          scan_off = BitOffW'(j);
        end
      end
    end
  end

  assign scan_end   = {1'b0, byte_cnt, scan_off};
  assign scan_start = scan_end + LenW'(1) - want;
  assign scan_last  = byte_cnt == nbytes_m1[AddrW-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (clr_addr == AddrW'(MaxBytes - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          if (in_indexed) begin
            state_next = in_bad_index ? ST_OUT : ST_BITOP;
          end else if (in_func == OpScan) begin
            state_next = in_scan_ok ? ST_SCAN : ST_OUT;
          end else if (in_func == OpWipe) begin
            state_next = ST_WIPE;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_BITOP: state_next = ST_OUT;
      ST_SCAN: begin
        if (scan_hit || scan_last) state_next = ST_OUT;
      end
      ST_WIPE: begin
        if (clr_addr == AddrW'(MaxBytes - 1)) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  // outputs and store port controls
  always_comb begin
    s_tready  = 1'b0;
    m_tvalid  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    mem_raddr = byte_cnt + AddrW'(1);
    case (state)
      ST_INIT, ST_WIPE: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        s_tready  = 1'b1;
        mem_raddr = (in_func == OpScan) ? '0 : in_pos[IndexW-1:BitOffW];
      end
      ST_BITOP: begin
        mem_waddr = pos[IndexW-1:BitOffW];
        mem_wdata = rdata;
        if (op == OpSet) begin
          mem_we = 1'b1;
          mem_wdata[pos[BitOffW-1:0]] = 1'b1;
        end else if (op == OpClear) begin
          mem_we = 1'b1;
          mem_wdata[pos[BitOffW-1:0]] = 1'b0;
        end
      end
      ST_OUT: begin
        m_tvalid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // mark store
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_INIT || state == ST_WIPE) begin
      clr_addr <= clr_addr + AddrW'(1);
    end else begin
      clr_addr <= '0;
    end
  end

  // request and result registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          op        <= in_func;
          pos       <= in_pos;
          want      <= in_want;
          run       <= '0;
          byte_cnt  <= '0;
          res_bit   <= 1'b0;
          res_found <= 1'b0;
          res_start <= '0;
          res_err   <= in_indexed && in_bad_index;
        end
      end
      ST_BITOP: begin
        if (op == OpTest) res_bit <= rdata[pos[BitOffW-1:0]];
      end
      ST_SCAN: begin
        run      <= scan_run;
        byte_cnt <= byte_cnt + AddrW'(1);
        if (scan_hit) begin
          res_found <= 1'b1;
          res_start <= scan_start[IndexW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign m_tdata = {1'b0, res_err, res_start, res_found, res_bit};

`ifndef NO_ASSERTIONS
  a_one_side: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("request taken while a result is pending");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready held after a request transfer");

  a_found_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res_found |-> !res_err && !res_bit)
    else $error("scan result carries indexed fields");

  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !res_found |-> res_start == '0)
    else $error("start index set without a found run");
`endif

endmodule
